### rtl/core/stack_with_undo_log_top_defines.svh
// ----------------------------------------------------------------------------
// Stack with undo log: assertion macros
// Shared macros for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_UNDO_LOG_TOP_DEFINES_SVH
`define STACK_WITH_UNDO_LOG_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWUL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWUL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/swul_pkg.sv
// ----------------------------------------------------------------------------
// Stack with undo log: package
// Request and status codes, record layout and controller states.
// ----------------------------------------------------------------------------
package swul_pkg;

  localparam int VALUE_W = 32;
  localparam int REC_W   = VALUE_W + 1;
  localparam int DEPTH_W = 7;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_PEEK = 2'd1,
    REQ_POP  = 2'd2,
    REQ_UNDO = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NO_UNDO = 2'd3
  } status_t;

  // Bit VALUE_W of a history record tells which operation it logged.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } swul_state_t;

endpackage

### rtl/core/swul_ram.sv
// ----------------------------------------------------------------------------
// Stack with undo log: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/stack_with_undo_log_top.sv
// ----------------------------------------------------------------------------
// Stack with undo log: top level
// Bounded stack of signed words with a ring of push and pop records that an
// undo request replays backwards.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      input      in_valid/in_ready   in_req_type, in_push_value
//  out_     output     out_valid/out_ready out_status, out_result_value,
//                                          out_depth_now
//
// Each request is handled in two steps: the first reads the stack top and the newest
// history record from their RAMs, the second updates and writes back.
// Reset is synchronous and active low; both RAMs need no clearing since only
// written entries are ever read.
// A result waiting in the output register does not block the next request;
// only the update cycle waits when the output register is still full.
// ----------------------------------------------------------------------------
`include "stack_with_undo_log_top_defines.svh"

module stack_with_undo_log_top #(
  parameter int STACK_DEPTH   = 64,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic signed [31:0] in_push_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_result_value,
  output logic [6:0]  out_depth_now
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);
  localparam int VW  = swul_pkg::VALUE_W;
  localparam int RW  = swul_pkg::REC_W;
  localparam int DW  = swul_pkg::DEPTH_W;

  localparam logic [CW-1:0]  STACK_FULL = CW'(STACK_DEPTH);
  localparam logic [HCW-1:0] HIST_FULL  = HCW'(HISTORY_DEPTH);
  localparam logic [HAW-1:0] HEAD_LAST  = HAW'(HISTORY_DEPTH - 1);

  swul_pkg::swul_state_t state_r, state_nxt;
  swul_pkg::req_kind_t   req_r;
  logic [VW-1:0]         push_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [HAW-1:0]        head_r, head_nxt;
  logic [HCW-1:0]        hcount_r, hcount_nxt;

  logic                  out_valid_r;
  swul_pkg::status_t     out_status_r, status_nxt;
  logic [VW-1:0]         out_value_r, result_nxt;
  logic [DW-1:0]         out_depth_r;

  logic                  in_fire;
  logic                  out_free;
  logic                  exec_done;
  logic [CW-1:0]         count_m1;
  logic [HAW-1:0]        head_prev;

  logic                  v_we;
  logic [SAW-1:0]        v_waddr;
  logic [VW-1:0]         v_wdata;
  logic [VW-1:0]         v_rdata;
  logic                  h_we;
  logic [RW-1:0]         h_wdata;
  logic [RW-1:0]         h_rdata;
  logic [DW+CW-1:0]      depth_ext;

  assign in_ready  = (state_r == swul_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign exec_done = (state_r == swul_pkg::S_EXEC) && out_free;
  assign count_m1  = count_r - 1'b1;
  assign head_prev = (head_r == '0) ? HEAD_LAST : head_r - 1'b1;

  swul_ram #(
    .WIDTH (VW),
    .DEPTH (STACK_DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (in_fire),
    .raddr (count_m1[SAW-1:0]),
    .rdata (v_rdata)
  );

  swul_ram #(
    .WIDTH (RW),
    .DEPTH (HISTORY_DEPTH)
  ) u_history_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (head_r),
    .wdata (h_wdata),
    .re    (in_fire),
    .raddr (head_prev),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swul_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    hcount_nxt = hcount_r;
    status_nxt = swul_pkg::ST_OK;
    result_nxt = '0;
    v_we       = 1'b0;
    v_waddr    = count_r[SAW-1:0];
    v_wdata    = push_r;
    h_we       = 1'b0;
    h_wdata    = {swul_pkg::KIND_PUSH, push_r};

    unique case (state_r)
      swul_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = swul_pkg::S_EXEC;
        end
      end
      swul_pkg::S_EXEC: begin
        unique case (req_r)
          swul_pkg::REQ_PUSH: begin
            if (count_r == STACK_FULL) begin
              status_nxt = swul_pkg::ST_FULL;
            end else begin
              v_we      = 1'b1;
              count_nxt = count_r + 1'b1;
              h_we      = 1'b1;
            end
          end
          swul_pkg::REQ_PEEK: begin
            if (count_r == '0) begin
              status_nxt = swul_pkg::ST_EMPTY;
            end else begin
              result_nxt = v_rdata;
            end
          end
          swul_pkg::REQ_POP: begin
            if (count_r == '0) begin
              status_nxt = swul_pkg::ST_EMPTY;
            end else begin
              count_nxt  = count_m1;
              result_nxt = v_rdata;
              h_we       = 1'b1;
              h_wdata    = {swul_pkg::KIND_POP, v_rdata};
            end
          end
          swul_pkg::REQ_UNDO: begin
            if (hcount_r == '0) begin
              status_nxt = swul_pkg::ST_NO_UNDO;
            end else begin
              // The record is consumed even when its reversal is impossible.
              head_nxt   = head_prev;
              hcount_nxt = hcount_r - 1'b1;
              if (h_rdata[VW] == swul_pkg::KIND_PUSH) begin
                if (count_r == '0) begin
                  status_nxt = swul_pkg::ST_EMPTY;
                end else begin
                  count_nxt  = count_m1;
                  result_nxt = h_rdata[VW-1:0];
                end
              end else begin
                if (count_r == STACK_FULL) begin
                  status_nxt = swul_pkg::ST_FULL;
                end else begin
                  v_we       = 1'b1;
                  v_wdata    = h_rdata[VW-1:0];
                  count_nxt  = count_r + 1'b1;
                  result_nxt = h_rdata[VW-1:0];
                end
              end
            end
          end
          default: begin
          end
        endcase

        if (h_we) begin
          head_nxt   = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;
          hcount_nxt = (hcount_r == HIST_FULL) ? hcount_r : hcount_r + 1'b1;
        end

        // Hold everything until the output register can take the result.
        if (exec_done) begin
          state_nxt = swul_pkg::S_IDLE;
        end else begin
          count_nxt  = count_r;
          head_nxt   = head_r;
          hcount_nxt = hcount_r;
          v_we       = 1'b0;
          h_we       = 1'b0;
        end
      end
      default: begin
        state_nxt = swul_pkg::S_IDLE;
      end
    endcase
  end

  assign depth_ext = {{DW{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      hcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      hcount_r <= hcount_nxt;
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r  <= swul_pkg::req_kind_t'(in_req_type);
      push_r <= in_push_value;
    end
    if (exec_done) begin
      out_status_r <= status_nxt;
      out_value_r  <= result_nxt;
      out_depth_r  <= depth_ext[DW-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_value = out_value_r;
  assign out_depth_now    = out_depth_r;

  `SWUL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= STACK_FULL, "stack count out of range")
  `SWUL_ASSERT_NOW(a_hcount_bound, clk, rst_n, 1'b1, hcount_r <= HIST_FULL, "history count out of range")
  `SWUL_ASSERT_NEXT(a_fire_to_exec, clk, rst_n, in_fire, state_r == swul_pkg::S_EXEC, "request not executed")
  `SWUL_ASSERT_NEXT(a_count_hold, clk, rst_n, !exec_done, $stable(count_r), "stack count moved without a result")

endmodule

### dv/stack_with_undo_log_checker.sv
// ----------------------------------------------------------------------------
// Stack with undo log: response checker
// Follows every accepted request with its own model of the stack and of the
// undo ring, queues the reply each request should get, and compares the
// replies on the result channel against them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stack_with_undo_log_checker #(
  parameter int STACK_DEPTH   = 64,
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic signed [swul_pkg::VALUE_W-1:0] in_push_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [1:0]                          out_status,
  input  logic signed [swul_pkg::VALUE_W-1:0] out_result_value,
  input  logic [swul_pkg::DEPTH_W-1:0]        out_depth_now,
  output int                                  fail_count,
  output int                                  pending
);

  typedef struct packed {
    swul_pkg::status_t                status;
    logic [swul_pkg::VALUE_W-1:0]     value;
    logic [swul_pkg::DEPTH_W-1:0]     depth;
  } stack_reply_t;

  stack_reply_t                 expected_replies[$];

  logic [swul_pkg::VALUE_W-1:0] cells [STACK_DEPTH];
  int unsigned                  cell_count;
  logic [swul_pkg::REC_W-1:0]   undo_log [HISTORY_DEPTH];
  int unsigned                  log_head;
  int unsigned                  log_count;

  task automatic report(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // The ring keeps the newest HISTORY_DEPTH records; older ones are overwritten.
  function automatic void log_op(logic kind, logic [swul_pkg::VALUE_W-1:0] value);
    undo_log[log_head] = {kind, value};
    log_head = (log_head + 1) % HISTORY_DEPTH;
    if (log_count < HISTORY_DEPTH) log_count++;
  endfunction

  function automatic stack_reply_t apply_request(swul_pkg::req_kind_t kind,
                                                 logic [swul_pkg::VALUE_W-1:0] value);
    stack_reply_t               r;
    logic [swul_pkg::REC_W-1:0] rec;
    r.status = swul_pkg::ST_OK;
    r.value  = '0;
    case (kind)
      swul_pkg::REQ_PUSH: begin
        if (cell_count >= STACK_DEPTH) begin
          r.status = swul_pkg::ST_FULL;
        end else begin
          cells[cell_count] = value;
          cell_count++;
          log_op(swul_pkg::KIND_PUSH, value);
        end
      end
      swul_pkg::REQ_PEEK: begin
        if (cell_count == 0) r.status = swul_pkg::ST_EMPTY;
        else r.value = cells[cell_count-1];
      end
      swul_pkg::REQ_POP: begin
        if (cell_count == 0) begin
          r.status = swul_pkg::ST_EMPTY;
        end else begin
          cell_count--;
          r.value = cells[cell_count];
          log_op(swul_pkg::KIND_POP, r.value);
        end
      end
      default: begin
        if (log_count == 0) begin
          r.status = swul_pkg::ST_NO_UNDO;
        end else begin
          log_head = (log_head + HISTORY_DEPTH - 1) % HISTORY_DEPTH;
          log_count--;
          rec = undo_log[log_head];
          // A record whose reversal is impossible is still consumed.
          if (rec[swul_pkg::VALUE_W] == swul_pkg::KIND_PUSH) begin
            if (cell_count == 0) begin
              r.status = swul_pkg::ST_EMPTY;
            end else begin
              cell_count--;
              r.value = rec[swul_pkg::VALUE_W-1:0];
            end
          end else begin
            if (cell_count >= STACK_DEPTH) begin
              r.status = swul_pkg::ST_FULL;
            end else begin
              cells[cell_count] = rec[swul_pkg::VALUE_W-1:0];
              cell_count++;
              r.value = rec[swul_pkg::VALUE_W-1:0];
            end
          end
        end
      end
    endcase
    r.depth = swul_pkg::DEPTH_W'(cell_count);
    return r;
  endfunction

  always @(posedge clk) begin
    stack_reply_t want;
    if (!rst_n) begin
      cell_count = 0;
      log_head   = 0;
      log_count  = 0;
      expected_replies.delete();
    end else begin
      if (in_valid && in_ready)
        expected_replies.push_back(
          apply_request(swul_pkg::req_kind_t'(in_req_type), in_push_value));
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report($sformatf("reply with no request outstanding: status %0d value %0h depth %0d",
                           out_status, out_result_value, out_depth_now));
        end else begin
          want = expected_replies.pop_front();
          if (out_status !== want.status)
            report($sformatf("status got %0d want %0d", out_status, want.status));
          if (out_result_value !== want.value)
            report($sformatf("result_value got %0h want %0h", out_result_value, want.value));
          if (out_depth_now !== want.depth)
            report($sformatf("depth_now got %0d want %0d", out_depth_now, want.depth));
        end
      end
    end
    pending = expected_replies.size();
  end

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Stack with undo log: testbench top
// Drives a directed opening and then segments of push, pop or undo heavy or
// evenly mixed traffic with random values through bursty requests and a
// stalling result side; the checker beside the block judges every reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int STACK_DEPTH   = 64;
  localparam int HISTORY_DEPTH = 64;
  localparam int RANDOM_ITEMS  = 1150;
  localparam int IDLE_LIMIT    = 2000;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_UNDO, MIX_EVEN} traffic_mix_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [1:0]                          in_req_type = swul_pkg::REQ_PEEK;
  logic signed [swul_pkg::VALUE_W-1:0] in_push_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [1:0]                          out_status;
  logic signed [swul_pkg::VALUE_W-1:0] out_result_value;
  logic [swul_pkg::DEPTH_W-1:0]        out_depth_now;

  int       fail_count;
  int       pending;
  int       burst_left = 0;
  int       idle_cycles = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always #1 clk = ~clk;

  stack_with_undo_log_top #(
    .STACK_DEPTH  (STACK_DEPTH),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .out_depth_now   (out_depth_now)
  );

  stack_with_undo_log_checker #(
    .STACK_DEPTH  (STACK_DEPTH),
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .out_depth_now   (out_depth_now),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // The result side picks its stall behavior at random and changes it when a countdown runs out.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(10, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= (rx_left[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("FAIL stack_with_undo_log_top");
        $finish;
      end
    end
  end

  // Holds the request until it is taken, then maybe idles before the next one.
  task automatic send_request(swul_pkg::req_kind_t kind,
                              logic [swul_pkg::VALUE_W-1:0] value);
    int gap;
    in_valid      <= 1'b1;
    in_req_type   <= kind;
    in_push_value <= value;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [swul_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic swul_pkg::req_kind_t pick_kind(traffic_mix_t mix);
    int r;
    int push_pct;
    int peek_pct;
    int pop_pct;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin push_pct = 75; peek_pct = 10; pop_pct = 10; end
      MIX_DRAIN: begin push_pct = 15; peek_pct = 10; pop_pct = 65; end
      MIX_UNDO:  begin push_pct = 10; peek_pct = 5;  pop_pct = 5;  end
      default:   begin push_pct = 25; peek_pct = 25; pop_pct = 25; end
    endcase
    if (r < push_pct) return swul_pkg::REQ_PUSH;
    if (r < push_pct + peek_pct) return swul_pkg::REQ_PEEK;
    if (r < push_pct + peek_pct + pop_pct) return swul_pkg::REQ_POP;
    return swul_pkg::REQ_UNDO;
  endfunction

  initial begin
    traffic_mix_t mix;
    int           seg_left;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Empty stack and empty log first.
    send_request(swul_pkg::REQ_PEEK, $urandom);
    send_request(swul_pkg::REQ_POP,  $urandom);
    send_request(swul_pkg::REQ_UNDO, $urandom);
    send_request(swul_pkg::REQ_PUSH, 32'h8000_0000);
    send_request(swul_pkg::REQ_PUSH, 32'h7FFF_FFFF);
    send_request(swul_pkg::REQ_PUSH, 32'h0000_0000);
    send_request(swul_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    send_request(swul_pkg::REQ_PEEK, $urandom);
    send_request(swul_pkg::REQ_POP,  $urandom);
    send_request(swul_pkg::REQ_POP,  $urandom);
    // Undo the two pops, then every push, then one more with the log empty.
    repeat (6) send_request(swul_pkg::REQ_UNDO, $urandom);
    send_request(swul_pkg::REQ_UNDO, $urandom);
    send_request(swul_pkg::REQ_PEEK, $urandom);
    send_request(swul_pkg::REQ_POP,  $urandom);
    wait_for_replies();

    // The first segment fills the stack so that overflow is reached early.
    mix      = MIX_FILL;
    seg_left = 150;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (seg_left == 0) begin
        mix      = traffic_mix_t'($urandom_range(0, 3));
        seg_left = $urandom_range(20, 150);
      end
      seg_left--;
      if (n == RANDOM_ITEMS / 2) wait_for_replies();
      send_request(pick_kind(mix), pick_value());
    end

    wait_for_replies();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS stack_with_undo_log_top");
    end else begin
      $display("FAIL stack_with_undo_log_top");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/swul_pkg.sv
rtl/core/swul_ram.sv
rtl/core/stack_with_undo_log_top.sv
dv/stack_with_undo_log_checker.sv
dv/testbench.sv
